// ===== rtl/schd_pkg.sv =====
package schd_pkg;

    // Fixed field widths
    localparam int STEP_W = 5;
    localparam int SYM_W  = 10;

    // Request opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic wr;        // store one codebook entry
        logic start;     // open a decode: clear index and length, take window
        logic rd;        // read the entry at the index and advance the index
        logic acc;       // add the pending entry's length step to the running length
        logic load_res;  // load the output register
        logic found;     // loaded result is a match
    } schd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic idx_done;  // index reached the entry limit
        logic hit;       // pending entry matches within the length limit
        logic over;      // running length passed the maximum code length
    } schd_status_t;

endpackage

// ===== rtl/schd_req_if.sv =====
interface schd_req_if #(
    parameter int MAX_CODE_LEN = 19,
    parameter int TABLE_DEPTH  = 256
);
    import schd_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic                    valid;
    logic                    ready;
    logic                    op;
    logic [IDX_W-1:0]        entry_index;
    logic [STEP_W-1:0]       entry_length_step;
    logic [MAX_CODE_LEN-1:0] entry_code;
    logic [SYM_W-1:0]        entry_symbol;
    logic [MAX_CODE_LEN-1:0] lookahead_bits;

    modport source (
        output valid, op, entry_index, entry_length_step, entry_code, entry_symbol,
               lookahead_bits,
        input  ready
    );

    modport sink (
        input  valid, op, entry_index, entry_length_step, entry_code, entry_symbol,
               lookahead_bits,
        output ready
    );

endinterface

// ===== rtl/schd_rsp_if.sv =====
interface schd_rsp_if #(
    parameter int MAX_CODE_LEN = 19
);
    import schd_pkg::*;

    localparam int BU_W = $clog2(MAX_CODE_LEN + 1);

    logic            valid;
    logic            ready;
    logic [SYM_W-1:0] symbol;
    logic [BU_W-1:0] bits_used;
    logic            no_match;

    modport source (
        output valid, symbol, bits_used, no_match,
        input  ready
    );

    modport sink (
        input  valid, symbol, bits_used, no_match,
        output ready
    );

endinterface

// ===== rtl/sorted_codebook_huffman_decoder.sv =====
// Huffman decoder over a codebook sorted by code length.
//
// Requests arrive on req (valid/ready). A write request (op = 0) stores one
// codebook entry (length step, codeword, symbol) and gives no
// result. A decode request (op = 1) carries a look-ahead window, first stream
// bit in the MSB; the codebook is scanned from entry 0, one entry per cycle
// through a registered memory read, keeping a running code length. The first
// entry whose codeword equals the top bits of the window returns its symbol
// and bits_used on rsp. No match within entries_in_use entries, or a running
// length past MAX_CODE_LEN, returns no_match with zero symbol and length.
// One request is in flight at a time; the next request can be taken in the
// same cycle in which the result appears. entries_in_use is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while idle, which the
// block does not enforce. Reset clears control state and sets entries_in_use
// to TABLE_DEPTH; the codebook contents are undefined until written. When rsp
// stalls, a finished result waits in the output register; the next scan may
// run, and holds at its end until the output register frees.
module sorted_codebook_huffman_decoder #(
    parameter int MAX_CODE_LEN = 19,
    parameter int TABLE_DEPTH  = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    schd_req_if.sink                         req,
    schd_rsp_if.source                       rsp,
    input  logic                             cfg_wr_en,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0] cfg_wr_data
);
    import schd_pkg::*;

    schd_cmd_t    cmd;
    schd_status_t status;

    // Sequencer
    schd_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Codebook memory, scan datapath and output register
    schd_datapath #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .TABLE_DEPTH  (TABLE_DEPTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .entry_index       (req.entry_index),
        .entry_length_step (req.entry_length_step),
        .entry_code        (req.entry_code),
        .entry_symbol      (req.entry_symbol),
        .lookahead_bits    (req.lookahead_bits),
        .symbol            (rsp.symbol),
        .bits_used         (rsp.bits_used),
        .no_match          (rsp.no_match)
    );

endmodule

// ===== rtl/schd_datapath.sv =====
module schd_datapath #(
    parameter int MAX_CODE_LEN = 19,
    parameter int TABLE_DEPTH  = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  schd_pkg::schd_cmd_t                   cmd,
    output schd_pkg::schd_status_t                status,
    input  logic                                  cfg_wr_en,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]      cfg_wr_data,
    input  logic [$clog2(TABLE_DEPTH)-1:0]        entry_index,
    input  logic [schd_pkg::STEP_W-1:0]           entry_length_step,
    input  logic [MAX_CODE_LEN-1:0]               entry_code,
    input  logic [schd_pkg::SYM_W-1:0]            entry_symbol,
    input  logic [MAX_CODE_LEN-1:0]               lookahead_bits,
    output logic [schd_pkg::SYM_W-1:0]            symbol,
    output logic [$clog2(MAX_CODE_LEN+1)-1:0]     bits_used,
    output logic                                  no_match
);
    import schd_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int RUN_W   = $clog2(MAX_CODE_LEN + 32);
    localparam int BU_W    = $clog2(MAX_CODE_LEN + 1);
    localparam int ENTRY_W = STEP_W + MAX_CODE_LEN + SYM_W;

    logic [ENTRY_W-1:0]      mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0]      rdata_reg;
    logic [CNT_W-1:0]        cfg_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic [RUN_W-1:0]        run_reg;
    logic [MAX_CODE_LEN-1:0] window_reg;
    logic [SYM_W-1:0]        sym_reg;
    logic [BU_W-1:0]         bits_reg;
    logic                    nomatch_reg;

    logic [CNT_W-1:0]        limit;
    logic [STEP_W-1:0]       rd_step;
    logic [MAX_CODE_LEN-1:0] rd_code;
    logic [SYM_W-1:0]        rd_sym;
    logic [RUN_W-1:0]        run_next;
    logic [RUN_W-1:0]        shamt;
    logic [MAX_CODE_LEN-1:0] cand;
    logic                    idx_in_range;

    // Entry limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CNT_W'(TABLE_DEPTH);
        end
        else if (cfg_wr_en)
        begin
            cfg_reg <= cfg_wr_data;
        end
    end

    // Saturate the limit at the table depth
    assign limit        = (cfg_reg > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : cfg_reg;
    assign idx_in_range = CNT_W'(entry_index) < CNT_W'(TABLE_DEPTH);

    // Codebook write port
    always_ff @(posedge clk)
    begin
        if (cmd.wr && idx_in_range)
        begin
            mem[entry_index] <= {entry_length_step, entry_code, entry_symbol};
        end
    end

    // Codebook read port, registered
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rdata_reg <= mem[idx_reg[IDX_W-1:0]];
        end
    end

    assign {rd_step, rd_code, rd_sym} = rdata_reg;

    // Compare the pending entry against the top bits of the window
    assign run_next = run_reg + RUN_W'(rd_step);
    assign shamt    = RUN_W'(MAX_CODE_LEN) - run_next;
    assign cand     = window_reg >> shamt;

    assign status.over     = run_next > RUN_W'(MAX_CODE_LEN);
    assign status.hit      = !status.over && (cand == rd_code);
    assign status.idx_done = idx_reg >= limit;

    // Scan index, running length and window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            run_reg <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.rd)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end

            if (cmd.start)
            begin
                run_reg <= '0;
            end
            else if (cmd.acc)
            begin
                run_reg <= run_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            window_reg <= lookahead_bits;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (cmd.load_res)
        begin
            sym_reg     <= cmd.found ? rd_sym : '0;
            bits_reg    <= cmd.found ? BU_W'(run_next) : '0;
            nomatch_reg <= !cmd.found;
        end
    end

    assign symbol    = sym_reg;
    assign bits_used = bits_reg;
    assign no_match  = nomatch_reg;

endmodule

// ===== rtl/schd_controller.sv =====
module schd_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic                   req_op,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output schd_pkg::schd_cmd_t    cmd,
    input  schd_pkg::schd_status_t status
);
    import schd_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;
    logic   out_valid_reg, out_valid_next;

    logic accept;
    logic finish;
    logic slot_free;
    logic scanning;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign accept    = req_valid && req_ready;
    assign scanning  = (state_reg == ST_SCAN);
    assign slot_free = !out_valid_reg || rsp_ready;

    // Stop on a match, on the length limit, or when no entry is left to read
    assign finish = (pend_reg && (status.hit || status.over)) || (!pend_reg && status.idx_done);

    // Commands
    always_comb
    begin
        cmd          = '0;
        cmd.wr       = accept && (req_op == OP_WRITE);
        cmd.start    = accept && (req_op == OP_DECODE);
        cmd.rd       = scanning && !finish && !status.idx_done;
        cmd.acc      = scanning && !finish && pend_reg;
        cmd.load_res = scanning && finish && slot_free;
        cmd.found    = pend_reg && status.hit;
    end

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        out_valid_next = rsp_ready ? 1'b0 : out_valid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                pend_next = 1'b0;
                if (cmd.start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cmd.load_res)
                begin
                    // hand the result over and return for the next request
                    state_next     = ST_IDLE;
                    pend_next      = 1'b0;
                    out_valid_next = 1'b1;
                end
                else if (!finish)
                begin
                    pend_next = cmd.rd;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/schd_checker.sv =====
module schd_checker #(
    parameter int MAX_CODE_LEN = 19
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input logic                              req_op,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic [schd_pkg::SYM_W-1:0]        rsp_symbol,
    input logic [$clog2(MAX_CODE_LEN+1)-1:0] rsp_bits_used,
    input logic                              rsp_no_match
);
    import schd_pkg::*;

    // After a decode request is accepted, req_ready drops to hold off the next request
    a_decode_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_op == OP_DECODE)) |=> !req_ready)
        else $error("decode request accepted but next request not held off");

    // A write request produces no result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_op == OP_WRITE) && !rsp_valid) |=> !rsp_valid)
        else $error("result appeared after a write request");

    // A result only appears at the end of a scan
    a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result appeared without a scan in progress");

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_symbol)
            && $stable(rsp_bits_used) && $stable(rsp_no_match)))
        else $error("stalled result changed or dropped");

endmodule

bind sorted_codebook_huffman_decoder schd_checker #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
) u_schd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_op        (req.op),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_symbol    (rsp.symbol),
    .rsp_bits_used (rsp.bits_used),
    .rsp_no_match  (rsp.no_match)
);
